>>> src/gcd_and_coprime_search_core_macros.svh
// ---------------------------------------------------------------------------
// GCD and coprime search core: assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef GCD_AND_COPRIME_SEARCH_CORE_MACROS_SVH
`define GCD_AND_COPRIME_SEARCH_CORE_MACROS_SVH

// same-cycle implication
`define GCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gcs_pkg.sv
// ---------------------------------------------------------------------------
// GCD and coprime search core: package
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcs_pkg;

  localparam int unsigned OperandWidthDef = 64;

  // result source selected by the controller
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_GCD,
    OUT_CAND,
    OUT_ONE
  } out_sel_e;

  typedef struct packed {
    logic     load_gcd;     // a <= x, b <= y
    logic     load_search;  // m <= x, candidate <= start value
    logic     load_cand;    // a <= candidate, b <= m
    logic     step;         // one binary gcd step
    logic     cand_dec;     // candidate -= 2
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic gcd_done;   // one of the pair reached zero
    logic gcd_one;    // finished gcd equals one
    logic cand_lt3;   // candidate cannot step down further
  } sts_t;

endpackage

>>> src/gcs_ctrl.sv
// ---------------------------------------------------------------------------
// GCD and coprime search core: controller
// Sequences gcd runs and the candidate search loop.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_and_coprime_search_core_macros.svh"

module gcs_ctrl
  import gcs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic action_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GCD   = 2'd1;
  localparam logic [1:0] S_SINIT = 2'd2;
  localparam logic [1:0] S_SGCD  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, out_sel: OUT_NONE};
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (action_i) begin
            cmd_o.load_search = 1'b1;
            state_d           = S_SINIT;
          end else begin
            cmd_o.load_gcd = 1'b1;
            state_d        = S_GCD;
          end
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.out_sel = OUT_GCD;
          state_d       = S_IDLE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_SINIT: begin
        cmd_o.load_cand = 1'b1;
        state_d         = S_SGCD;
      end
      S_SGCD: begin
        if (sts_i.gcd_done) begin
          if (sts_i.gcd_one) begin
            cmd_o.out_sel = OUT_CAND;
            state_d       = S_IDLE;
          end else if (sts_i.cand_lt3) begin
            cmd_o.out_sel = OUT_ONE;
            state_d       = S_IDLE;
          end else begin
            cmd_o.cand_dec = 1'b1;
            state_d        = S_SINIT;
          end
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  `GCS_ASSERT_NEXT(a_start_leaves_idle, clk_i, rst_ni, start_i && !busy_o,
                   state_q != S_IDLE, "accepted item did not leave idle")
  `GCS_ASSERT_NEXT(a_gcd_finishes, clk_i, rst_ni, (state_q == S_GCD) && sts_i.gcd_done,
                   state_q == S_IDLE, "finished gcd did not return to idle")
  `GCS_ASSERT_IMP(a_out_from_run, clk_i, rst_ni, cmd_o.out_sel != OUT_NONE,
                  (state_q == S_GCD) || (state_q == S_SGCD), "result issued outside a gcd run")

endmodule

>>> src/gcs_datapath.sv
// ---------------------------------------------------------------------------
// GCD and coprime search core: datapath
// Binary gcd pair, search candidate, modulus and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gcd_and_coprime_search_core_macros.svh"

module gcs_datapath
  import gcs_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  input  logic [OPERAND_WIDTH-1:0] first_operand_i,
  input  logic [OPERAND_WIDTH-1:0] second_operand_i,
  output sts_t                     sts_o,
  output logic                     answer_valid_o,
  output logic [OPERAND_WIDTH-1:0] answer_o
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned KW = $clog2(W);

  logic [W-1:0]  a_q, a_d, b_q, b_d;
  logic [KW-1:0] k_q, k_d;
  logic [W-1:0]  m_q, m_d, cand_q, cand_d;
  logic [W-1:0]  answer_q, answer_d;
  logic          valid_q;

  logic [W-1:0] a_or_b, gcd_val, a_minus_b, b_minus_a, cand_init;

  assign a_or_b    = a_q | b_q;
  assign gcd_val   = a_or_b << k_q;
  assign a_minus_b = a_q - b_q;
  assign b_minus_a = b_q - a_q;

  always_comb begin
    cand_init = (first_operand_i > W'(3)) ? (first_operand_i - W'(1)) : W'(1);
    if (!cand_init[0]) begin
      cand_init = cand_init - W'(1);
    end
  end

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    k_d = k_q;
    if (cmd_i.load_gcd) begin
      a_d = first_operand_i;
      b_d = second_operand_i;
      k_d = '0;
    end else if (cmd_i.load_cand) begin
      a_d = cand_q;
      b_d = m_q;
      k_d = '0;
    end else if (cmd_i.step) begin
      if (!a_q[0] && !b_q[0]) begin
        // common factor of two, restored at the output shift
        a_d = a_q >> 1;
        b_d = b_q >> 1;
        k_d = k_q + KW'(1);
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_q >= b_q) begin
        a_d = a_minus_b >> 1;
      end else begin
        b_d = b_minus_a >> 1;
      end
    end
  end

  always_comb begin
    m_d    = m_q;
    cand_d = cand_q;
    if (cmd_i.load_search) begin
      m_d    = first_operand_i;
      cand_d = cand_init;
    end else if (cmd_i.cand_dec) begin
      cand_d = cand_q - W'(2);
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      OUT_GCD:  answer_d = gcd_val;
      OUT_CAND: answer_d = cand_q;
      OUT_ONE:  answer_d = W'(1);
      default:  answer_d = answer_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= '0;
      b_q      <= '0;
      k_q      <= '0;
      m_q      <= '0;
      cand_q   <= '0;
      answer_q <= '0;
    end else begin
      a_q      <= a_d;
      b_q      <= b_d;
      k_q      <= k_d;
      m_q      <= m_d;
      cand_q   <= cand_d;
      answer_q <= answer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (cmd_i.out_sel != OUT_NONE);
    end
  end

  assign sts_o.gcd_done = (a_q == '0) || (b_q == '0);
  assign sts_o.gcd_one  = (a_or_b == W'(1)) && (k_q == '0);
  assign sts_o.cand_lt3 = (cand_q < W'(3));

  assign answer_valid_o = valid_q;
  assign answer_o       = answer_q;

  `GCS_ASSERT_NEXT(a_single_strobe, clk_i, rst_ni, valid_q, !valid_q,
                   "result strobe held two cycles")
  `GCS_ASSERT_IMP(a_step_nonzero, clk_i, rst_ni, cmd_i.step,
                  (a_q != '0) && (b_q != '0), "gcd step on a finished pair")
  `GCS_ASSERT_NEXT(a_cand_odd, clk_i, rst_ni, cmd_i.load_search, cand_q[0],
                   "search candidate not odd")

endmodule

>>> src/gcd_and_coprime_search_core.sv
// ---------------------------------------------------------------------------
// GCD and coprime search core: top level
// gcd of two operands, or an odd multiplier coprime to a modulus.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | start && !busy          | action_i, first_operand_i,
//          |                         | second_operand_i
//  out     | answer_valid_o (1 cycle)| answer_o
//
//  Steps: one binary gcd step per cycle. A search needs a single gcd
//  (M-1, or M-2 for odd M, is coprime). One item at a time; busy is
//  high meanwhile.
//  Reset: async, active low; returns to idle, no result pending.
//  The result strobe cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_and_coprime_search_core
  import gcs_pkg::*;
#(
  parameter int unsigned OPERAND_WIDTH = OperandWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action_i,
  input  logic [OPERAND_WIDTH-1:0] first_operand_i,
  input  logic [OPERAND_WIDTH-1:0] second_operand_i,
  output logic                     answer_valid_o,
  output logic [OPERAND_WIDTH-1:0] answer_o
);

  cmd_t cmd;
  sts_t sts;

  gcs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  gcs_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .sts_o            (sts),
    .answer_valid_o   (answer_valid_o),
    .answer_o         (answer_o)
  );

endmodule

>>> dv/gcd_and_coprime_search_core_test.sv
// ---------------------------------------------------------------------------
// GCD and coprime search core: testbench
// Drives gcd and coprime search items with random gaps and predicts each
// answer with Euclid's remainder method. Every strobed answer is compared
// in order against the predicted answers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcd_and_coprime_search_core_test;

  localparam int unsigned W = gcs_pkg::OperandWidthDef;

  localparam logic ACT_GCD     = 1'b0;
  localparam logic ACT_COPRIME = 1'b1;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned SETTLE_CYCLES = 300;  // past the longest search
  localparam int unsigned QUIET_LIMIT = 5000;

  typedef logic [W-1:0] operand_t;

  class answer_book;
    operand_t expected_answers[$];
    int unsigned failures;

    function operand_t gcd_of(operand_t x, operand_t y);
      operand_t r;
      while (y != '0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    function operand_t coprime_multiplier(operand_t m);
      operand_t cand;
      bit found;
      cand  = (m > 3) ? m - 1 : operand_t'(1);
      found = 1'b0;
      if (!cand[0]) cand = cand - 1;
      while (!found) begin
        if (gcd_of(cand, m) == operand_t'(1)) begin
          found = 1'b1;
        end else if (cand < 3) begin
          cand  = 1;
          found = 1'b1;
        end else begin
          cand = cand - 2;
        end
      end
      return cand;
    endfunction

    function void note_item(logic act, operand_t a, operand_t b);
      if (act == ACT_GCD) expected_answers.push_back(gcd_of(a, b));
      else expected_answers.push_back(coprime_multiplier(a));
    endfunction

    function void check_answer(operand_t answer);
      operand_t want;
      if (expected_answers.size() == 0) begin
        failures++;
        $error("answer: unexpected result 0x%016h, none pending", answer);
        return;
      end
      want = expected_answers.pop_front();
      if (answer !== want) begin
        failures++;
        $error("answer: expected 0x%016h, got 0x%016h", want, answer);
      end
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  logic     busy;
  logic     action_i;
  operand_t first_operand_i;
  operand_t second_operand_i;
  logic     answer_valid_o;
  operand_t answer_o;

  answer_book  book;
  int unsigned quiet_cycles = 0;
  bit          burst_mode = 1'b0;

  gcd_and_coprime_search_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .first_operand_i  (first_operand_i),
    .second_operand_i (second_operand_i),
    .answer_valid_o   (answer_valid_o),
    .answer_o         (answer_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // sampled values here are the ones the block saw at this edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (start && !busy) book.note_item(action_i, first_operand_i, second_operand_i);
      if (answer_valid_o) book.check_answer(answer_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((start && !busy) || answer_valid_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("** gcd_and_coprime_search_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic operand_t rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic operand_t rand_operand();
    case ($urandom_range(0, 7))
      0: return operand_t'($urandom_range(0, 20));
      1: return '1 - operand_t'($urandom_range(0, 20));
      2: return operand_t'(1) << $urandom_range(0, W - 1);
      3: return rand_word() >> $urandom_range(1, W - 1);
      default: return rand_word();
    endcase
  endfunction

  // start stays high until the item is taken; the caller decides when to drop it
  task automatic send_item(logic act, operand_t a, operand_t b);
    start            <= 1'b1;
    action_i         <= act;
    first_operand_i  <= a;
    second_operand_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic hold_off(int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    operand_t a;
    operand_t b;
    operand_t g;
    logic     act;

    book = new;
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    action_i         <= ACT_GCD;
    first_operand_i  <= '0;
    second_operand_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gcd corners: zeros, extremes, powers of two, worst-case Euclid pair
    send_item(ACT_GCD, '0, '0);
    send_item(ACT_GCD, 64'd12345, '0);
    hold_off(2);
    send_item(ACT_GCD, '0, 64'd9876);
    send_item(ACT_GCD, '1, '1);
    send_item(ACT_GCD, '1, 64'd1);
    hold_off(1);
    send_item(ACT_GCD, '1, '1 - 1);
    send_item(ACT_GCD, 64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_item(ACT_GCD, 64'd12200160415121876738, 64'd7540113804746346429);
    send_item(ACT_GCD, 64'd7540113804746346429, 64'd12200160415121876738);
    send_item(ACT_GCD, 64'd1071, 64'd462);
    hold_off(7);
    // coprime search: small moduli, even and odd, extremes; second operand ignored
    send_item(ACT_COPRIME, 64'd0, '1);
    send_item(ACT_COPRIME, 64'd1, '0);
    send_item(ACT_COPRIME, 64'd2, 64'd5);
    send_item(ACT_COPRIME, 64'd3, '0);
    send_item(ACT_COPRIME, 64'd4, '0);
    hold_off(1);
    send_item(ACT_COPRIME, 64'd5, rand_word());
    send_item(ACT_COPRIME, 64'd9, '0);
    send_item(ACT_COPRIME, '1, '1);
    send_item(ACT_COPRIME, '1 - 1, '0);
    send_item(ACT_COPRIME, 64'h8000_0000_0000_0000, '0);
    send_item(ACT_COPRIME, 64'd1000000007, '0);
    drain();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      act = $urandom_range(0, 1);
      if (act == ACT_GCD && $urandom_range(0, 3) == 0) begin
        // shared factor so the gcd is not trivially one
        g = (rand_word() >> $urandom_range(40, W - 1)) + 1;
        a = g * (rand_word() >> $urandom_range(24, W - 1));
        b = g * (rand_word() >> $urandom_range(24, W - 1));
      end else begin
        a = rand_operand();
        b = rand_operand();
      end
      send_item(act, a, b);
      if (i == RANDOM_ITEMS / 2) drain();
      else hold_off(pick_gap());
    end
    start <= 1'b0;

    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (book.failures == 0) begin
      $display("** gcd_and_coprime_search_core: PASSED **");
    end else begin
      $display("** gcd_and_coprime_search_core: FAILED **");
    end
    $finish;
  end

endmodule
